### rtl/tcal_pkg.sv
// Package for the lowest-common-ancestor block: sizes of the node fields,
// the ancestor and depth memories, and the address helpers.
// Depends on nothing; used by tree_common_ancestor_lifting.
package tcal_pkg;

	localparam int MAX_NODES   = 4096;
	localparam int LIFT_LEVELS = 12;

	localparam int NODE_W  = 13;
	localparam int BOSS_W  = 12;
	localparam int DEPTH_W = 12;
	localparam int IDX_W   = $clog2(MAX_NODES);
	localparam int LVL_W   = $clog2(LIFT_LEVELS);
	localparam int ANC_DEPTH = MAX_NODES * LIFT_LEVELS;
	localparam int ADDR_W  = $clog2(ANC_DEPTH);

	localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [DEPTH_W-1:0] depth_t;
	typedef logic [LVL_W-1:0] lvl_t;

	function automatic logic node_ok(input node_t node);
		return (node != '0) && (node <= NODE_W'(MAX_NODES));
	endfunction

	// Node numbers start at 1, so node n lives in row n - 1.
	function automatic logic [IDX_W-1:0] node_idx(input node_t node);
		logic [NODE_W-1:0] m;
		m = node - NODE_W'(1);
		return m[IDX_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] anc_addr(input node_t node, input lvl_t lvl);
		return ADDR_W'(node_idx(node)) * ADDR_W'(LIFT_LEVELS) + ADDR_W'(lvl);
	endfunction

endpackage

### rtl/tree_common_ancestor_lifting.sv
// Lowest common ancestor by binary lifting, with the ancestor and depth
// tables held in synchronous memories. Uses tcal_pkg.
//
// Channel  | Signals                                         | Transfer
// ---------+-------------------------------------------------+--------------------------
// command  | start, busy, mode, employee, boss,              | start high and busy low
//          | query_first, query_second                       |
// result   | done, common_ancestor                           | each cycle done is high
//
// A load writes one ancestor entry per cycle, each read from the entry written
// just before it, so the memory read latency sets the pace. A query with both
// nodes in range runs a depth read, one lift step per level, a meeting check,
// one jump step per level and a step for the answer, each a dependent memory
// read; done is registered from the answer step. A query that meets after
// lifting answers from the meeting check and skips the jump steps; a query naming
// an out-of-range node answers in the cycle after its transfer. The memories need
// no clearing after reset; the root's entries are produced by logic. Results
// cannot be stalled: done lasts one cycle and the next command may transfer in
// that cycle.
module tree_common_ancestor_lifting (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   mode,
	input  tcal_pkg::node_t        employee,
	input  logic [tcal_pkg::BOSS_W-1:0] boss,
	input  tcal_pkg::node_t        query_first,
	input  tcal_pkg::node_t        query_second,
	output logic                   done,
	output tcal_pkg::node_t        common_ancestor
);
	import tcal_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_QDEP,
		S_LIFT,
		S_MEET,
		S_JUMP,
		S_RES
	} state_t;

	localparam lvl_t LVL_TOP = LVL_W'(LIFT_LEVELS - 1);

	state_t state_q;
	lvl_t   k_q;
	node_t  a_q, b_q, e_q;
	logic [LIFT_LEVELS-1:0] dist_q;
	logic   took_q, ra_q, rb_q, fwd_q;
	node_t  fwd_data_q;
	logic   done_q;
	node_t  result_q;

	node_t anc_mem [ANC_DEPTH];
	depth_t dep_mem [MAX_NODES];
	node_t  anc_rd_a_q, anc_rd_b_q;
	depth_t dep_rd_a_q, dep_rd_b_q;

	logic              anc_we, dep_we;
	logic [ADDR_W-1:0] anc_waddr, anc_raddr_a, anc_raddr_b;
	node_t             anc_wdata;
	logic [IDX_W-1:0]  dep_waddr, dep_raddr_a, dep_raddr_b;
	depth_t            dep_wdata;
	node_t             rd_node_a, rd_node_b;
	lvl_t              lvl_a, lvl_b;

	node_t  rd_a_val, rd_b_val, a_lift, a_jmp, b_jmp;
	depth_t dep_a_val, dep_b_val, depth_diff;
	logic   accept, load_ok, query_ok, jump_upd, a_deeper;

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign common_ancestor = result_q;
	assign accept          = start && !busy;

	assign load_ok  = (employee >= NODE_W'(2)) && (employee <= NODE_W'(MAX_NODES))
		&& node_ok(NODE_W'(boss));
	assign query_ok = node_ok(query_first) && node_ok(query_second);

	// The root is never written: its ancestors are itself and its depth is zero.
	assign rd_a_val  = fwd_q ? fwd_data_q : (ra_q ? ROOT_NODE : anc_rd_a_q);
	assign rd_b_val  = rb_q ? ROOT_NODE : anc_rd_b_q;
	assign dep_a_val = ra_q ? '0 : dep_rd_a_q;
	assign dep_b_val = rb_q ? '0 : dep_rd_b_q;

	assign a_deeper   = (dep_a_val >= dep_b_val);
	assign depth_diff = a_deeper ? (dep_a_val - dep_b_val) : (dep_b_val - dep_a_val);

	assign a_lift   = took_q ? rd_a_val : a_q;
	assign jump_upd = (rd_a_val != rd_b_val);
	assign a_jmp    = jump_upd ? rd_a_val : a_q;
	assign b_jmp    = jump_upd ? rd_b_val : b_q;

	always_comb begin
		rd_node_a = a_q;
		rd_node_b = b_q;
		lvl_a     = k_q;
		lvl_b     = k_q;
		anc_we    = 1'b0;
		anc_waddr = anc_addr(e_q, k_q);
		anc_wdata = rd_a_val;
		dep_we    = 1'b0;
		dep_waddr = node_idx(e_q);
		dep_wdata = dep_a_val + DEPTH_W'(1);
		dep_raddr_a = node_idx(a_q);
		dep_raddr_b = node_idx(b_q);
		case (state_q)
			S_IDLE: begin
				rd_node_a   = mode ? query_first : NODE_W'(boss);
				rd_node_b   = query_second;
				lvl_a       = '0;
				lvl_b       = '0;
				anc_we      = start && !mode && load_ok;
				anc_waddr   = anc_addr(employee, '0);
				anc_wdata   = NODE_W'(boss);
				dep_raddr_a = node_idx(rd_node_a);
				dep_raddr_b = node_idx(query_second);
			end
			S_LOAD: begin
				rd_node_a = rd_a_val;
				anc_we    = 1'b1;
				dep_we    = (k_q == LVL_W'(1));
			end
			S_LIFT: begin
				rd_node_a = a_lift;
			end
			S_MEET: begin
				rd_node_a = a_lift;
				lvl_a     = LVL_TOP;
				lvl_b     = LVL_TOP;
			end
			S_JUMP: begin
				rd_node_a = a_jmp;
				rd_node_b = b_jmp;
				lvl_a     = k_q - LVL_W'(1);
				lvl_b     = k_q - LVL_W'(1);
				if (k_q == '0) begin
					lvl_a = '0;
					lvl_b = '0;
				end
			end
			default: begin
			end
		endcase
		anc_raddr_a = anc_addr(rd_node_a, lvl_a);
		anc_raddr_b = anc_addr(rd_node_b, lvl_b);
	end

	always_ff @(posedge clk) begin
		if (anc_we) begin
			anc_mem[anc_waddr] <= anc_wdata;
		end
		anc_rd_a_q <= anc_mem[anc_raddr_a];
		anc_rd_b_q <= anc_mem[anc_raddr_b];
	end

	always_ff @(posedge clk) begin
		if (dep_we) begin
			dep_mem[dep_waddr] <= dep_wdata;
		end
		dep_rd_a_q <= dep_mem[dep_raddr_a];
		dep_rd_b_q <= dep_mem[dep_raddr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			k_q        <= '0;
			a_q        <= '0;
			b_q        <= '0;
			e_q        <= '0;
			dist_q     <= '0;
			took_q     <= 1'b0;
			ra_q       <= 1'b0;
			rb_q       <= 1'b0;
			fwd_q      <= 1'b0;
			fwd_data_q <= '0;
			done_q     <= 1'b0;
			result_q   <= '0;
		end else begin
			done_q <= 1'b0;
			ra_q   <= (rd_node_a == ROOT_NODE);
			rb_q   <= (rd_node_b == ROOT_NODE);
			// A read on port a of the entry being written in the same cycle sees the new value.
			fwd_q      <= anc_we && (anc_waddr == anc_raddr_a);
			fwd_data_q <= anc_wdata;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						e_q <= employee;
						a_q <= query_first;
						b_q <= query_second;
						k_q <= LVL_W'(1);
						if (!mode) begin
							if (load_ok) begin
								state_q <= S_LOAD;
							end
						end else if (query_ok) begin
							state_q <= S_QDEP;
						end else begin
							done_q   <= 1'b1;
							result_q <= '0;
						end
					end
				end
				S_LOAD: begin
					k_q <= k_q + LVL_W'(1);
					if (k_q == LVL_TOP) begin
						state_q <= S_IDLE;
					end
				end
				S_QDEP: begin
					a_q     <= a_deeper ? a_q : b_q;
					b_q     <= a_deeper ? b_q : a_q;
					dist_q  <= depth_diff[LIFT_LEVELS-1:0];
					k_q     <= '0;
					took_q  <= 1'b0;
					state_q <= S_LIFT;
				end
				S_LIFT: begin
					a_q    <= a_lift;
					took_q <= dist_q[k_q];
					k_q    <= k_q + LVL_W'(1);
					if (k_q == LVL_TOP) begin
						state_q <= S_MEET;
					end
				end
				S_MEET: begin
					a_q <= a_lift;
					k_q <= LVL_TOP;
					if (a_lift == b_q) begin
						done_q   <= 1'b1;
						result_q <= a_lift;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_JUMP;
					end
				end
				S_JUMP: begin
					a_q <= a_jmp;
					b_q <= b_jmp;
					if (k_q == '0) begin
						state_q <= S_RES;
					end else begin
						k_q <= k_q - LVL_W'(1);
					end
				end
				S_RES: begin
					done_q   <= 1'b1;
					result_q <= rd_a_val;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a command is still in progress");

	a_write_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		anc_we |-> (state_q == S_LOAD || (state_q == S_IDLE && start && !mode)))
		else $error("ancestor memory written outside a load");

	a_bad_query: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode && !query_ok) |=> (done && common_ancestor == '0))
		else $error("out-of-range query did not answer zero at once");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !mode && load_ok) |=> (busy && !done))
		else $error("accepted load did not start its write sequence");

	a_fwd_load: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_q |-> ($past(state_q) == S_LOAD || $past(state_q) == S_IDLE))
		else $error("write forwarding outside a load");

endmodule
